/* rtl/sac_pkg.sv */
// shared constants and types for the set associative cache tag model
package sac_pkg;

  localparam int OUT_W          = 48;
  localparam int CNT_W          = 32;
  localparam int MAX_BLOCK_BITS = 12;
  localparam int SHIFT_W        = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_LFU    = 3'd3;

  localparam logic [2:0] RST_SET_BITS   = 3'd6;
  localparam logic [3:0] RST_BLOCK_BITS = 4'd6;
  localparam logic [3:0] RST_WAYS       = 4'd8;
  localparam logic       RST_USE_LFU    = 1'b0;

  localparam logic [1:0] ST_HIT   = 2'd0;
  localparam logic [1:0] ST_FILL  = 2'd1;
  localparam logic [1:0] ST_EVICT = 2'd2;

  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_flags_t;

endpackage

/* rtl/set_assoc_cache_lru_lfu.sv */
// top level of the set associative cache tag model with lru or lfu replacement
//
// channel  ports                              role
// in       in_valid in_ready in_address       one byte address per transfer
// out      out_valid out_ready out_status ... one result per transfer, totals included
// cfg      cfg_we cfg_index cfg_wdata         register write, no wait
//
// one transfer per cycle while out_ready is high; result passes stages a, b and out
// set row read goes through the registered row memory port
// a write to the set just read is forwarded into the compare stage
// reset clears the per-row initialized flags at once, no clearing pass
// out_ready low holds the result and backs up the stages behind it
module set_assoc_cache_lru_lfu #(
  parameter int ADDR_BITS    = 48,
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [ADDR_BITS-1:0]             in_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic [sac_pkg::OUT_W-1:0]        out_evicted_block,
  output logic [sac_pkg::OUT_W-1:0]        out_access_block,
  output logic [sac_pkg::CNT_W-1:0]        out_hit_total,
  output logic [sac_pkg::CNT_W-1:0]        out_miss_total,
  output logic [sac_pkg::CNT_W-1:0]        out_evict_total,
  input  logic                             cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW     = sac_pkg::CNT_W;
  localparam int OW     = sac_pkg::OUT_W;
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int LINE_W = 1 + 2*ADDR_BITS + 2*CW;
  localparam int ROW_W  = CW + WAYS*LINE_W;
  localparam int EXT_W  = (ADDR_BITS > OW) ? ADDR_BITS : OW;

  logic [2:0] cfg_sbits_r;
  logic [3:0] cfg_bbits_r;
  logic [3:0] cfg_ways_r;
  logic       cfg_lfu_r;

  logic [2:0]                   sbits;
  logic [3:0]                   bbits;
  logic [sac_pkg::SHIFT_W-1:0]  shamt;
  logic [WAYS-1:0]              way_en;

  logic                 a_vld_r;
  logic [ADDR_BITS-1:0] a_addr_r;
  logic [ADDR_BITS-1:0] a_shift;
  logic [SET_W-1:0]     a_set;
  logic [ADDR_BITS-1:0] a_tag;
  logic [ADDR_BITS-1:0] a_blk;

  logic                 b_vld_r;
  logic [SET_W-1:0]     b_set_r;
  logic [ADDR_BITS-1:0] b_tag_r;
  logic [ADDR_BITS-1:0] b_blk_r;
  logic                 fwd_r;
  logic [ROW_W-1:0]     fwd_row_r;
  logic [ROW_W-1:0]     rd_row;
  logic                 rd_init;
  logic [ROW_W-1:0]     b_row;
  logic [ROW_W-1:0]     new_row;
  logic [ADDR_BITS-1:0] evict_blk;
  sac_pkg::lookup_flags_t flags;

  logic          out_vld_r;
  logic [1:0]    out_status_r;
  logic [OW-1:0] out_victim_r;
  logic [OW-1:0] out_insert_r;
  logic [CW-1:0] hit_r;
  logic [CW-1:0] miss_r;
  logic [CW-1:0] evict_r;
  logic [CW-1:0] hit_nxt;
  logic [CW-1:0] miss_nxt;
  logic [CW-1:0] evict_nxt;
  logic [1:0]    status_nxt;
  logic [EXT_W-1:0] victim_ext;
  logic [EXT_W-1:0] insert_ext;

  logic a_vld_nxt;
  logic b_vld_nxt;
  logic out_vld_nxt;
  logic out_can;
  logic b_fire;
  logic a_move;
  logic in_xfer;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sbits_r <= sac_pkg::RST_SET_BITS;
      cfg_bbits_r <= sac_pkg::RST_BLOCK_BITS;
      cfg_ways_r  <= sac_pkg::RST_WAYS;
      cfg_lfu_r   <= sac_pkg::RST_USE_LFU;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sac_pkg::CFG_SET_BITS:   cfg_sbits_r <= cfg_wdata[2:0];
        sac_pkg::CFG_BLOCK_BITS: cfg_bbits_r <= cfg_wdata[3:0];
        sac_pkg::CFG_WAYS:       cfg_ways_r  <= cfg_wdata[3:0];
        sac_pkg::CFG_USE_LFU:    cfg_lfu_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign sbits = (int'(cfg_sbits_r) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg_sbits_r;
  assign bbits = (cfg_bbits_r > 4'(sac_pkg::MAX_BLOCK_BITS)) ?
                 4'(sac_pkg::MAX_BLOCK_BITS) : cfg_bbits_r;
  assign shamt = sac_pkg::SHIFT_W'(sbits) + sac_pkg::SHIFT_W'(bbits);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      way_en[w] = (w == 0) || (w < int'(cfg_ways_r));
    end
  end

  // handshake
  assign out_can = !out_vld_r || out_ready;
  assign b_fire  = b_vld_r && out_can;
  assign a_move  = a_vld_r && (!b_vld_r || b_fire);
  assign in_ready = !a_vld_r || a_move;
  assign in_xfer = in_valid && in_ready;

  assign a_vld_nxt   = in_xfer ? 1'b1 : (a_move ? 1'b0 : a_vld_r);
  assign b_vld_nxt   = a_move ? 1'b1 : (b_fire ? 1'b0 : b_vld_r);
  assign out_vld_nxt = b_fire ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      fwd_r     <= 1'b0;
    end else begin
      a_vld_r   <= a_vld_nxt;
      b_vld_r   <= b_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (a_move) begin
        fwd_r <= b_fire && (b_set_r == a_set);
      end
    end
  end

  // address split
  assign a_shift = a_addr_r >> bbits;
  assign a_tag   = a_addr_r >> shamt;

  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      a_set[i] = a_shift[i] && (i < int'(sbits));
    end
    for (int i = 0; i < ADDR_BITS; i++) begin
      a_blk[i] = a_addr_r[i] && (i >= int'(bbits));
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_addr_r <= in_address;
    end
    if (a_move) begin
      b_set_r <= a_set;
      b_tag_r <= a_tag;
      b_blk_r <= a_blk;
    end
    if (b_fire) begin
      fwd_row_r <= new_row;
    end
  end

  sac_row_ram #(
    .ADDR_W(SET_W),
    .DATA_W(ROW_W)
  ) u_row_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (a_move),
    .rd_addr(a_set),
    .rd_data(rd_row),
    .rd_init(rd_init),
    .wr_en  (b_fire),
    .wr_addr(b_set_r),
    .wr_data(new_row)
  );

  assign b_row = fwd_r ? fwd_row_r : (rd_init ? rd_row : {ROW_W{1'b0}});

  sac_lookup #(
    .ADDR_BITS(ADDR_BITS),
    .WAYS     (WAYS)
  ) u_lookup (
    .row_i      (b_row),
    .tag_i      (b_tag_r),
    .blk_i      (b_blk_r),
    .way_en_i   (way_en),
    .use_lfu_i  (cfg_lfu_r),
    .row_o      (new_row),
    .flags_o    (flags),
    .evict_blk_o(evict_blk)
  );

  // result and totals
  assign status_nxt = flags.hit ? sac_pkg::ST_HIT :
                      (flags.evict ? sac_pkg::ST_EVICT : sac_pkg::ST_FILL);
  assign hit_nxt   = (flags.hit && (hit_r != {CW{1'b1}})) ? hit_r + 1'b1 : hit_r;
  assign miss_nxt  = (!flags.hit && (miss_r != {CW{1'b1}})) ? miss_r + 1'b1 : miss_r;
  assign evict_nxt = (flags.evict && (evict_r != {CW{1'b1}})) ? evict_r + 1'b1 : evict_r;
  assign victim_ext = EXT_W'(evict_blk);
  assign insert_ext = EXT_W'(b_blk_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= '0;
      miss_r  <= '0;
      evict_r <= '0;
    end else if (b_fire) begin
      hit_r   <= hit_nxt;
      miss_r  <= miss_nxt;
      evict_r <= evict_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_status_r <= status_nxt;
      out_victim_r <= victim_ext[OW-1:0];
      out_insert_r <= insert_ext[OW-1:0];
    end
  end

  assign out_valid         = out_vld_r;
  assign out_status        = out_status_r;
  assign out_evicted_block = out_victim_r;
  assign out_access_block  = out_insert_r;
  assign out_hit_total     = hit_r;
  assign out_miss_total    = miss_r;
  assign out_evict_total   = evict_r;

  a_hit_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_status_r == sac_pkg::ST_HIT) |-> out_victim_r == '0)
    else $error("hit result carries a victim block");

  a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
    evict_r <= miss_r)
    else $error("eviction total exceeds miss total");

  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    b_fire && !flags.hit && (miss_r != {CW{1'b1}}) |=> miss_r == $past(miss_r) + 1'b1)
    else $error("miss total did not advance on a miss");

endmodule

/* rtl/sac_row_ram.sv */
// set row memory with registered read and per-row initialized flags
module sac_row_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  output logic              rd_init,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  init_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_init_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r    <= '0;
      rd_init_r <= 1'b0;
    end else begin
      if (wr_en) begin
        init_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_init_r <= init_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_init = rd_init_r;

endmodule

/* rtl/sac_victim.sv */
// replacement victim select over the ways of one set, as a compare tree
module sac_victim #(
  parameter int WAYS = 8
) (
  input  logic [WAYS*sac_pkg::CNT_W-1:0]          stamp_i,
  input  logic [WAYS*sac_pkg::CNT_W-1:0]          uses_i,
  input  logic [WAYS-1:0]                         way_en_i,
  input  logic                                    use_lfu_i,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] pick_o
);

  localparam int CW        = sac_pkg::CNT_W;
  localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LVLS      = $clog2(WAYS);
  localparam int P         = 1 << LVLS;
  localparam int KEY_W     = 2 * CW;

  logic [P*CW-1:0]      stamp_pad;
  logic [P*CW-1:0]      uses_pad;
  logic [P-1:0]         en_pad;
  logic                 node_en  [LVLS+1][P];
  logic [KEY_W-1:0]     node_key [LVLS+1][P];
  logic [WAY_IDX_W-1:0] node_idx [LVLS+1][P];

  assign stamp_pad = (P*CW)'(stamp_i);
  assign uses_pad  = (P*CW)'(uses_i);
  assign en_pad    = P'(way_en_i);

  always_comb begin
    for (int l = 0; l <= LVLS; l++) begin
      for (int j = 0; j < P; j++) begin
        node_en[l][j]  = 1'b0;
        node_key[l][j] = '0;
        node_idx[l][j] = '0;
      end
    end
    for (int j = 0; j < P; j++) begin
      node_en[0][j]  = en_pad[j];
      node_key[0][j] = {(use_lfu_i ? uses_pad[j*CW +: CW] : {CW{1'b0}}),
                        stamp_pad[j*CW +: CW]};
      node_idx[0][j] = WAY_IDX_W'(j);
    end
    // lower way sits on the left, ties stay left
    for (int l = 0; l < LVLS; l++) begin
      for (int j = 0; j < P/2; j++) begin
        if (node_en[l][2*j+1] &&
            (!node_en[l][2*j] || (node_key[l][2*j+1] < node_key[l][2*j]))) begin
          node_en[l+1][j]  = node_en[l][2*j+1];
          node_key[l+1][j] = node_key[l][2*j+1];
          node_idx[l+1][j] = node_idx[l][2*j+1];
        end else begin
          node_en[l+1][j]  = node_en[l][2*j];
          node_key[l+1][j] = node_key[l][2*j];
          node_idx[l+1][j] = node_idx[l][2*j];
        end
      end
    end
  end

  assign pick_o = node_idx[LVLS][0];

endmodule

/* rtl/sac_lookup.sv */
// tag compare, fill or victim choice and row update for one access
module sac_lookup #(
  parameter int ADDR_BITS = 48,
  parameter int WAYS      = 8
) (
  input  logic [sac_pkg::CNT_W+WAYS*(1+2*ADDR_BITS+2*sac_pkg::CNT_W)-1:0] row_i,
  input  logic [ADDR_BITS-1:0]     tag_i,
  input  logic [ADDR_BITS-1:0]     blk_i,
  input  logic [WAYS-1:0]          way_en_i,
  input  logic                     use_lfu_i,
  output logic [sac_pkg::CNT_W+WAYS*(1+2*ADDR_BITS+2*sac_pkg::CNT_W)-1:0] row_o,
  output sac_pkg::lookup_flags_t   flags_o,
  output logic [ADDR_BITS-1:0]     evict_blk_o
);

  localparam int CW        = sac_pkg::CNT_W;
  localparam int LINE_W    = 1 + 2*ADDR_BITS + 2*CW;
  localparam int WAY_IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SOFS      = CW;
  localparam int BOFS      = 2*CW;
  localparam int TOFS      = 2*CW + ADDR_BITS;
  localparam int VOFS      = 2*CW + 2*ADDR_BITS;

  logic [WAYS-1:0]      valid;
  logic [WAYS-1:0]      match;
  logic [WAYS-1:0]      empty;
  logic [ADDR_BITS-1:0] tag   [WAYS];
  logic [ADDR_BITS-1:0] blk   [WAYS];
  logic [CW-1:0]        stamp [WAYS];
  logic [CW-1:0]        uses  [WAYS];
  logic [WAYS*CW-1:0]   stamp_flat;
  logic [WAYS*CW-1:0]   uses_flat;
  logic [WAY_IDX_W-1:0] hit_idx;
  logic [WAY_IDX_W-1:0] empty_idx;
  logic [WAY_IDX_W-1:0] vic_idx;
  logic [WAY_IDX_W-1:0] pick;
  logic                 hit;
  logic                 has_empty;
  logic [CW-1:0]        clk_old;
  logic [CW-1:0]        clk_new;
  logic [CW-1:0]        uses_hit;
  logic [CW-1:0]        uses_inc;

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    assign uses[w]  = row_i[CW + w*LINE_W +: CW];
    assign stamp[w] = row_i[CW + w*LINE_W + SOFS +: CW];
    assign blk[w]   = row_i[CW + w*LINE_W + BOFS +: ADDR_BITS];
    assign tag[w]   = row_i[CW + w*LINE_W + TOFS +: ADDR_BITS];
    assign valid[w] = row_i[CW + w*LINE_W + VOFS];
    assign match[w] = way_en_i[w] && valid[w] && (tag[w] == tag_i);
    assign empty[w] = way_en_i[w] && !valid[w];
    assign stamp_flat[w*CW +: CW] = stamp[w];
    assign uses_flat[w*CW +: CW]  = uses[w];
  end

  sac_victim #(
    .WAYS(WAYS)
  ) u_victim (
    .stamp_i  (stamp_flat),
    .uses_i   (uses_flat),
    .way_en_i (way_en_i),
    .use_lfu_i(use_lfu_i),
    .pick_o   (vic_idx)
  );

  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_idx = WAY_IDX_W'(w);
      end
      if (empty[w]) begin
        empty_idx = WAY_IDX_W'(w);
      end
    end
  end

  assign hit       = |match;
  assign has_empty = |empty;
  assign pick      = hit ? hit_idx : (has_empty ? empty_idx : vic_idx);

  assign clk_old  = row_i[CW-1:0];
  assign clk_new  = (clk_old == {CW{1'b1}}) ? clk_old : clk_old + 1'b1;
  assign uses_hit = uses[hit_idx];
  assign uses_inc = (uses_hit == {CW{1'b1}}) ? uses_hit : uses_hit + 1'b1;

  always_comb begin
    int base;
    row_o         = row_i;
    row_o[CW-1:0] = clk_new;
    for (int w = 0; w < WAYS; w++) begin
      base = CW + w*LINE_W;
      if (WAY_IDX_W'(w) == pick) begin
        row_o[base + SOFS +: CW] = clk_new;
        if (hit) begin
          row_o[base +: CW] = uses_inc;
        end else begin
          row_o[base +: CW]               = CW'(1);
          row_o[base + BOFS +: ADDR_BITS] = blk_i;
          row_o[base + TOFS +: ADDR_BITS] = tag_i;
          row_o[base + VOFS]              = 1'b1;
        end
      end
    end
  end

  assign flags_o.hit   = hit;
  assign flags_o.evict = !hit && !has_empty;
  assign evict_blk_o   = (!hit && !has_empty) ? blk[vic_idx] : '0;

endmodule
